@@ rtl/fucd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fucd_pkg
// Shared types and constants of the framed uart command device.
// ----------------------------------------------------------------------------
package fucd_pkg;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_ENABLE  = 2'd1,
    CMD_DISABLE = 2'd2,
    CMD_STATUS  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_NOP    = 2'd0,
    OP_HK     = 2'd1,
    OP_SENSOR = 2'd2,
    OP_CONFIG = 2'd3
  } op_e;

  localparam int unsigned MsgLen  = 9;
  localparam int unsigned LenOver = 10;
  localparam int unsigned CntW    = 4;
  localparam int unsigned QDepth  = 2;

  localparam logic [7:0] HdrHi = 8'hDE;
  localparam logic [7:0] HdrLo = 8'hAD;
  localparam logic [7:0] TrlHi = 8'hBE;
  localparam logic [7:0] TrlLo = 8'hEF;

  localparam logic [15:0] OffsetBin = 16'h8000;

  // reply layout: echo, DE AD, count, word 1, word 2, BE EF
  localparam int unsigned ReplyMax = 25;
  localparam int unsigned IdxW     = 5;
  localparam logic [IdxW-1:0] LastEcho   = 5'd8;
  localparam logic [IdxW-1:0] LastHk     = 5'd24;
  localparam logic [IdxW-1:0] LastSensor = 5'd22;

  // one reply, snapshot of everything it will send
  typedef struct packed {
    logic [MsgLen-1:0][7:0] msg;
    op_e                    op;
    logic [31:0]            cnt;
    logic [31:0]            w1;
    logic [31:0]            w2;
  } job_t;

endpackage
`default_nettype wire

@@ rtl/fucd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fucd_in_if / fucd_out_if
// Valid/ready channels carrying input items and reply bytes.
// ----------------------------------------------------------------------------
interface fucd_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  cmd;
  logic        [7:0]  rx_byte;
  logic               end_of_message;
  logic        [31:0] status_value;
  logic signed [15:0] sensor_x;
  logic signed [15:0] sensor_y;
  logic signed [15:0] sensor_z;

  modport source (output valid, cmd, rx_byte, end_of_message, status_value,
                  sensor_x, sensor_y, sensor_z, input ready);
  modport sink   (input valid, cmd, rx_byte, end_of_message, status_value,
                  sensor_x, sensor_y, sensor_z, output ready);
endinterface

interface fucd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;

  modport source (output valid, tx_byte, last_byte, input ready);
  modport sink   (input valid, tx_byte, last_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/framed_uart_command_device.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ending byte taken -> job queued -> first reply byte registered and offered
// throughput: one input item per cycle; replies drain one byte per ready cycle
// input stalls only while the reply queue of QueueDepth jobs is full
// reset: asynchronous active low; device enabled, counter, config, status cleared
// the message buffer is not reset and is always written before it is read
// ----------------------------------------------------------------------------
// framed_uart_command_device
// Framed command receiver with echo and housekeeping/sensor reply frames.
// ----------------------------------------------------------------------------
module framed_uart_command_device #(
  parameter int unsigned QueueDepth = fucd_pkg::QDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fucd_in_if.sink   in_i,
  fucd_out_if.source out_o
);
  import fucd_pkg::*;

  job_t push_job;
  logic push;
  logic full;
  job_t head_job;
  logic head_vld;
  logic pop;

  fucd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .job_o  (push_job),
    .push_o (push),
    .full_i (full)
  );

  fucd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .valid_o (head_vld),
    .job_o   (head_job),
    .pop_i   (pop)
  );

  fucd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (head_vld),
    .job_i   (head_job),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire

@@ rtl/fucd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fucd_front
// Takes input items, buffers message bytes, checks framing, keeps the device
// registers and pushes one reply job per answered message.
// ----------------------------------------------------------------------------
module fucd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  fucd_in_if.sink            in_i,
  output fucd_pkg::job_t     job_o,
  output logic               push_o,
  input  wire logic          full_i
);
  import fucd_pkg::*;

  logic [7:0]      buf_q [MsgLen];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            en_q, en_d;
  logic [31:0]     seq_q, seq_d;
  logic [31:0]     cfg_q, cfg_d;
  logic [31:0]     stat_q, stat_d;

  logic       acc;
  logic       msg_ok;
  logic [7:0] op;
  logic       op_ok;

  assign in_i.ready = !full_i;
  assign acc        = in_i.valid && in_i.ready;

  assign op     = buf_q[2];
  assign op_ok  = (op[7:2] == 6'd0);
  // the ninth byte is the one arriving now
  assign msg_ok = en_q && (cnt_q == CntW'(MsgLen - 1)) &&
                  (buf_q[0] == HdrHi) && (buf_q[1] == HdrLo) &&
                  (buf_q[MsgLen-2] == TrlHi) && (in_i.rx_byte == TrlLo);

  always_comb begin
    for (int i = 0; i < MsgLen - 1; i++) begin
      job_o.msg[i] = buf_q[i];
    end
    job_o.msg[MsgLen-1] = in_i.rx_byte;
    job_o.op            = op_e'(op[1:0]);
    job_o.cnt           = seq_q + 32'd1;
    if (op_e'(op[1:0]) == OP_HK) begin
      job_o.w1 = cfg_q;
      job_o.w2 = stat_q;
    end else begin
      job_o.w1 = {in_i.sensor_x ^ OffsetBin, in_i.sensor_y ^ OffsetBin};
      job_o.w2 = {in_i.sensor_z ^ OffsetBin, TrlHi, TrlLo};
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    en_d   = en_q;
    seq_d  = seq_q;
    cfg_d  = cfg_q;
    stat_d = stat_q;
    push_o = 1'b0;
    if (acc) begin
      unique case (cmd_e'(in_i.cmd))
        CMD_ENABLE: begin
          en_d = 1'b1;
        end
        CMD_DISABLE: begin
          en_d   = 1'b0;
          seq_d  = '0;
          cfg_d  = '0;
          stat_d = '0;
        end
        CMD_STATUS: begin
          stat_d = in_i.status_value;
        end
        CMD_BYTE: begin
          if (cnt_q < CntW'(LenOver)) begin
            cnt_d = cnt_q + CntW'(1);
          end
          if (in_i.end_of_message) begin
            cnt_d = '0;
            if (msg_ok) begin
              seq_d  = seq_q + 32'd1 + {31'd0, op_ok};
              push_o = op_ok;
              if (op_ok && (op_e'(op[1:0]) == OP_CONFIG)) begin
                cfg_d = {buf_q[3], buf_q[4], buf_q[5], buf_q[6]};
              end
            end
          end
        end
        default: begin
          en_d = en_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      en_q   <= 1'b1;
      seq_q  <= '0;
      cfg_q  <= '0;
      stat_q <= '0;
    end else begin
      cnt_q  <= cnt_d;
      en_q   <= en_d;
      seq_q  <= seq_d;
      cfg_q  <= cfg_d;
      stat_q <= stat_d;
    end
  end

  // message bytes past the ninth are dropped
  always_ff @(posedge clk_i) begin
    if (acc && (cmd_e'(in_i.cmd) == CMD_BYTE) && (cnt_q < CntW'(MsgLen))) begin
      buf_q[cnt_q] <= in_i.rx_byte;
    end
  end

endmodule
`default_nettype wire

@@ rtl/fucd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fucd_queue
// Short first-in first-out queue of reply jobs between front and back.
// ----------------------------------------------------------------------------
module fucd_queue #(
  parameter int unsigned Depth = fucd_pkg::QDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire fucd_pkg::job_t job_i,
  output logic                full_o,
  output logic                valid_o,
  output fucd_pkg::job_t      job_o,
  input  wire logic           pop_i
);
  import fucd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FillW = $clog2(Depth + 1);

  job_t             mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == FillW'(Depth));
  assign valid_o = (fill_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   fill_d = fill_q + FillW'(1);
      2'b01:   fill_d = fill_q - FillW'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/fucd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fucd_back
// Serializes the job at the queue head into reply bytes through an output
// register, one per cycle while the sink is ready.
// ----------------------------------------------------------------------------
module fucd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire fucd_pkg::job_t job_i,
  output logic                pop_o,
  fucd_out_if.source          out_o
);
  import fucd_pkg::*;

  logic [7:0]      frame [ReplyMax];
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] last_idx;
  logic            vld_q, vld_d;
  logic [7:0]      byte_q, byte_d;
  logic            lst_q, lst_d;
  logic            adv;
  logic            at_end;

  always_comb begin
    for (int i = 0; i < MsgLen; i++) begin
      frame[i] = job_i.msg[i];
    end
    frame[MsgLen]      = HdrHi;
    frame[MsgLen + 1]  = HdrLo;
    for (int i = 0; i < 4; i++) begin
      frame[MsgLen + 2 + i]  = job_i.cnt[31 - 8*i -: 8];
      frame[MsgLen + 6 + i]  = job_i.w1[31 - 8*i -: 8];
      frame[MsgLen + 10 + i] = job_i.w2[31 - 8*i -: 8];
    end
    frame[ReplyMax - 2] = TrlHi;
    frame[ReplyMax - 1] = TrlLo;
  end

  always_comb begin
    unique case (job_i.op)
      OP_HK:     last_idx = LastHk;
      OP_SENSOR: last_idx = LastSensor;
      default:   last_idx = LastEcho;
    endcase
  end

  assign adv    = !vld_q || out_o.ready;
  assign at_end = (idx_q == last_idx);
  assign pop_o  = adv && valid_i && at_end;

  always_comb begin
    idx_d  = idx_q;
    vld_d  = vld_q;
    byte_d = byte_q;
    lst_d  = lst_q;
    if (adv) begin
      vld_d = valid_i;
      if (valid_i) begin
        byte_d = frame[idx_q];
        lst_d  = at_end;
        idx_d  = at_end ? '0 : idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    lst_q  <= lst_d;
  end

  assign out_o.valid     = vld_q;
  assign out_o.tx_byte   = byte_q;
  assign out_o.last_byte = lst_q;

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the framed uart command device: drives command
// messages, control items and noise, predicts every echo and reply frame,
// and compares each transmitted byte as it leaves the block.
// ----------------------------------------------------------------------------
module tb_top;
  import fucd_pkg::*;

  localparam int unsigned RandItems   = 216;
  localparam int unsigned IdlePct     = 22;
  localparam int unsigned HoldOff     = 300;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned MaxReports  = 10;

  typedef logic [7:0] byte_q_t[$];

  // tracks device state and the reply bytes it owes
  class reply_tracker;
    typedef struct packed {
      logic [7:0] tx;
      logic       last;
    } reply_byte_t;

    logic [7:0]  msg_buf [MsgLen];
    int unsigned rx_count;
    bit          enabled;
    logic [31:0] seq_count;
    logic [31:0] dev_config;
    logic [31:0] dev_status;
    reply_byte_t owed_bytes[$];

    int unsigned mismatches;
    int unsigned bytes_seen;
    int unsigned items_taken;
    int unsigned silent_msgs;
    int unsigned replies [4];

    function new();
      rx_count   = 0;
      enabled    = 1'b1;
      seq_count  = '0;
      dev_config = '0;
      dev_status = '0;
    endfunction

    function void put(logic [7:0] b);
      owed_bytes.push_back(reply_byte_t'{tx: b, last: 1'b0});
    endfunction

    function void put_word(logic [31:0] w);
      put(w[31:24]);
      put(w[23:16]);
      put(w[15:8]);
      put(w[7:0]);
    endfunction

    function void put_reading(logic [15:0] r);
      logic [15:0] v;
      v = r ^ OffsetBin;
      put(v[15:8]);
      put(v[7:0]);
    endfunction

    function void close_message(logic [15:0] sx, logic [15:0] sy, logic [15:0] sz);
      op_e op;
      if (!enabled || rx_count != MsgLen ||
          msg_buf[0] != HdrHi || msg_buf[1] != HdrLo ||
          msg_buf[7] != TrlHi || msg_buf[8] != TrlLo) begin
        silent_msgs++;
        return;
      end
      seq_count++;
      // well formed but unknown opcode: counted once, never answered
      if (msg_buf[2] > 8'(OP_CONFIG)) begin
        silent_msgs++;
        return;
      end
      op = op_e'(msg_buf[2][1:0]);
      if (op == OP_CONFIG) begin
        dev_config = {msg_buf[3], msg_buf[4], msg_buf[5], msg_buf[6]};
      end
      for (int i = 0; i < MsgLen; i++) put(msg_buf[i]);
      if (op == OP_HK || op == OP_SENSOR) begin
        put(HdrHi);
        put(HdrLo);
        put_word(seq_count);
        if (op == OP_HK) begin
          put_word(dev_config);
          put_word(dev_status);
        end else begin
          put_reading(sx);
          put_reading(sy);
          put_reading(sz);
        end
        put(TrlHi);
        put(TrlLo);
      end
      seq_count++;
      owed_bytes[owed_bytes.size() - 1].last = 1'b1;
      replies[op]++;
    endfunction

    function void note_item(cmd_e cmd, logic [7:0] rx, logic eom, logic [31:0] status,
                            logic [15:0] sx, logic [15:0] sy, logic [15:0] sz);
      items_taken++;
      case (cmd)
        CMD_ENABLE: begin
          enabled = 1'b1;
        end
        CMD_DISABLE: begin
          enabled    = 1'b0;
          seq_count  = '0;
          dev_config = '0;
          dev_status = '0;
        end
        CMD_STATUS: begin
          dev_status = status;
        end
        default: begin
          if (rx_count < MsgLen) msg_buf[rx_count] = rx;
          if (rx_count < LenOver) rx_count++;
          if (eom) begin
            close_message(sx, sy, sz);
            rx_count = 0;
          end
        end
      endcase
    endfunction

    function void check_byte(logic [7:0] tx, logic last);
      reply_byte_t want;
      bytes_seen++;
      if (owed_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("unexpected reply byte: tx_byte %02h last_byte %0b", tx, last);
        end
        return;
      end
      want = owed_bytes.pop_front();
      if (want.tx !== tx || want.last !== last) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("reply byte %0d: expected tx_byte %02h last_byte %0b, got %02h %0b",
                   bytes_seen, want.tx, want.last, tx, last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  fucd_in_if  in_ch ();
  fucd_out_if out_ch ();

  framed_uart_command_device dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  reply_tracker tracker;
  bit           quiet_phase = 1'b0;
  int unsigned  hold_left   = 0;
  int unsigned  cycles      = 0;
  int unsigned  in_stalls   = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // reply side: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = quiet_phase || ($urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (rst_n && in_ch.valid && !in_ch.ready) in_stalls++;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tracker.check_byte(out_ch.tx_byte, out_ch.last_byte);
    end
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d reply bytes still owed",
               cycles, tracker.owed_bytes.size());
      $display("framed_uart_command_device verification failed");
      $finish;
    end
  end

  function automatic logic [15:0] rand_reading();
    int v;
    v = $urandom_range(65534);
    return 16'(v - 32767);
  endfunction

  function automatic byte_q_t well_formed(logic [7:0] op, logic [31:0] arg);
    return '{HdrHi, HdrLo, op, arg[31:24], arg[23:16], arg[15:8], arg[7:0], TrlHi, TrlLo};
  endfunction

  task automatic send_item(cmd_e cmd, logic [7:0] rx, logic eom, logic [31:0] status,
                           logic [15:0] sx, logic [15:0] sy, logic [15:0] sz);
    if (!quiet_phase) begin
      while ($urandom_range(99) < IdlePct) begin
        in_ch.valid = 1'b0;
        @(negedge clk);
      end
    end
    in_ch.valid          = 1'b1;
    in_ch.cmd            = cmd;
    in_ch.rx_byte        = rx;
    in_ch.end_of_message = eom;
    in_ch.status_value   = status;
    in_ch.sensor_x       = sx;
    in_ch.sensor_y       = sy;
    in_ch.sensor_z       = sz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_item(cmd, rx, eom, status, sx, sy, sz);
    @(negedge clk);
  endtask

  task automatic send_ctl(cmd_e cmd, logic [31:0] status);
    send_item(cmd, 8'($urandom), 1'($urandom), status,
              rand_reading(), rand_reading(), rand_reading());
  endtask

  // control item slipped in before byte ctl_at, if ctl_at is in range
  task automatic send_msg(byte_q_t msg, logic [15:0] sx, logic [15:0] sy, logic [15:0] sz,
                          int ctl_at = -1);
    int last_idx;
    last_idx = msg.size() - 1;
    for (int i = 0; i <= last_idx; i++) begin
      if (i == ctl_at) begin
        send_ctl(cmd_e'($urandom_range(1) ? CMD_STATUS : CMD_ENABLE), $urandom);
      end
      send_item(CMD_BYTE, msg[i], i == last_idx, $urandom, sx, sy, sz);
    end
  endtask

  task automatic send_random_round();
    byte_q_t     msg;
    int unsigned pick;
    int unsigned r;
    logic [7:0]  op;
    cmd_e        cmd;
    pick = $urandom_range(99);
    r    = $urandom_range(9);
    op   = (r < 9) ? 8'(r % 4) : 8'($urandom_range(255, 4));
    msg  = well_formed(op, $urandom);
    if (pick < 55) begin
      send_msg(msg, rand_reading(), rand_reading(), rand_reading(),
               ($urandom_range(9) == 0) ? int'($urandom_range(8, 1)) : -1);
    end else if (pick < 67) begin
      if (!tracker.enabled) begin
        cmd = cmd_e'(($urandom_range(3) != 0) ? CMD_ENABLE : CMD_STATUS);
      end else if (r < 5) begin
        cmd = CMD_STATUS;
      end else if (r < 8) begin
        cmd = CMD_ENABLE;
      end else begin
        cmd = CMD_DISABLE;
      end
      send_ctl(cmd, $urandom);
    end else if (pick < 76) begin
      // too long: extra bytes past the ninth
      repeat ($urandom_range(4, 1)) msg.push_back(8'($urandom));
      send_msg(msg, rand_reading(), rand_reading(), rand_reading());
    end else if (pick < 88) begin
      case ($urandom_range(4))
        0: msg[0] = msg[0] ^ 8'($urandom_range(255, 1));
        1: msg[1] = msg[1] ^ 8'($urandom_range(255, 1));
        2: msg[7] = msg[7] ^ 8'($urandom_range(255, 1));
        3: msg[8] = msg[8] ^ 8'($urandom_range(255, 1));
        default: begin
          r = $urandom_range(8, 1);
          while (msg.size() > r) void'(msg.pop_back());
        end
      endcase
      send_msg(msg, rand_reading(), rand_reading(), rand_reading());
    end else begin
      msg.delete();
      repeat ($urandom_range(12, 1)) msg.push_back(8'($urandom));
      send_msg(msg, rand_reading(), rand_reading(), rand_reading());
    end
  endtask

  initial begin
    int unsigned rand_start;
    tracker              = new();
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.cmd            = CMD_BYTE;
    in_ch.rx_byte        = '0;
    in_ch.end_of_message = 1'b0;
    in_ch.status_value   = '0;
    in_ch.sensor_x       = '0;
    in_ch.sensor_y       = '0;
    in_ch.sensor_z       = '0;
    out_ch.ready         = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: all-ones status and config, housekeeping, sensor extremes
    send_ctl(CMD_STATUS, 32'hFFFF_FFFF);
    send_msg(well_formed(8'(OP_CONFIG), 32'hFFFF_FFFF), 16'h0000, 16'h0000, 16'h0000);
    send_msg(well_formed(8'(OP_HK), 32'h0000_0000), 16'h0000, 16'h0000, 16'h0000);
    send_msg(well_formed(8'(OP_SENSOR), $urandom), 16'h8001, 16'h7FFF, 16'h0000);

    // reply side held off while full-size replies keep coming in
    hold_left = HoldOff;
    for (int i = 0; i < 4; i++) begin
      send_msg(well_formed(8'(i[0] ? OP_SENSOR : OP_HK), $urandom),
               rand_reading(), rand_reading(), rand_reading());
    end

    rand_start = tracker.items_taken;
    while (tracker.items_taken < rand_start + RandItems) begin
      quiet_phase = (tracker.items_taken >= rand_start + 120) &&
                    (tracker.items_taken < rand_start + 180);
      send_random_round();
    end
    quiet_phase = 1'b0;
    in_ch.valid = 1'b0;

    while (tracker.owed_bytes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("took %0d items; replies: %0d no-op, %0d housekeeping, %0d sensor, %0d config",
             tracker.items_taken, tracker.replies[OP_NOP], tracker.replies[OP_HK],
             tracker.replies[OP_SENSOR], tracker.replies[OP_CONFIG]);
    $display("%0d reply bytes checked, %0d messages unanswered, %0d input stall cycles",
             tracker.bytes_seen, tracker.silent_msgs, in_stalls);
    if (tracker.mismatches == 0 && tracker.owed_bytes.size() == 0) begin
      $display("framed_uart_command_device verification clean");
    end else begin
      $display("%0d mismatches", tracker.mismatches);
      $display("framed_uart_command_device verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/fucd_pkg.sv
rtl/fucd_if.sv
rtl/fucd_front.sv
rtl/fucd_queue.sv
rtl/fucd_back.sv
rtl/framed_uart_command_device.sv
tb/sv/tb_top.sv
